@@ sv/sphbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sphbc_pkg
// Shared types, register codes and fixed-point constants for the spectrum
// peak-hold and band colour block.
// ----------------------------------------------------------------------------
package sphbc_pkg;

  // Configuration port
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_DECAY    = 2'd0,
    REG_BASS_END = 2'd1,
    REG_MID_END  = 2'd2,
    REG_BANDS    = 2'd3
  } reg_idx_t;

  localparam logic [15:0] DECAY_RESET    = 16'd32113;
  localparam logic [8:0]  BASS_END_RESET = 9'd10;
  localparam logic [8:0]  MID_END_RESET  = 9'd100;
  localparam logic [8:0]  BANDS_RESET    = 9'd256;
  localparam int          DECAY_SHIFT    = 15;

  // Band class
  typedef enum logic [1:0] {
    CLS_BASS = 2'd0,
    CLS_MID  = 2'd1,
    CLS_HIGH = 2'd2
  } band_cls_t;

  // Energy sums
  localparam int SUM_W = 24;
  typedef logic [SUM_W-1:0] sum_t;

  // Colour mapping: product width, gains, reciprocals of 6 and 10
  localparam int          COL_PROD_W   = SUM_W + 8;
  localparam logic [7:0]  COL_GAIN     = 8'd255;
  localparam logic [7:0]  BRT_GAIN     = 8'd155;
  localparam logic [7:0]  COL_MAX      = 8'd255;
  localparam logic [7:0]  BRT_BASE     = 8'd100;
  localparam int          QX_W         = 11;
  localparam int          RECIP_SHIFT  = 18;
  localparam int          QM_W         = 27;
  localparam logic [15:0] COL_RECIP    = 16'd43691;
  localparam logic [15:0] BRT_RECIP    = 16'd26215;
  localparam logic [COL_PROD_W-1:0] COL_SAT_X = COL_PROD_W'(1536);
  localparam logic [COL_PROD_W-1:0] BRT_SAT_X = COL_PROD_W'(1560);

  // Control from the band pipeline to the colour mapper
  typedef struct packed {
    logic load_prod;
    logic load_hold;
  } cmap_ctl_t;

  // Saturating sum of an energy sum and a zero-extended peak
  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

@@ sv/spectrum_peak_hold_band_colour.sv @@
// ----------------------------------------------------------------------------
// spectrum_peak_hold_band_colour
// Spectrum peak hold with per-frame decay and band-energy colour mapping.
//
// Input channel (in_valid / in_stall, magnitude): one band magnitude word per
// cycle, in band order. Output channel (out_valid / out_stall): one result
// word per input word, carrying the updated held peak, the band index, a
// frame_done flag on the last band of a frame, and the colours and
// brightness of the last completed frame (already new on frame_done).
// A word is taken every cycle while in_stall is low. The peak store is one RAM
// with registered read data, read as a word is accepted and written back as
// the word moves from stage 1 to stage 2; a repeat of the same band in the
// next word takes the new peak from a bypass register. After reset the block
// clears the peak store, one entry a cycle, for all BANDS entries; in_stall
// is high during that pass. Configuration writes are taken at all times. When
// the receiver stalls, the result holds and the internal stages fill; in_stall
// rises only once every stage is full.
// ----------------------------------------------------------------------------
module spectrum_peak_hold_band_colour #(
  parameter int BANDS    = 256,
  parameter int MAG_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // Band input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [MAG_BITS-1:0]          magnitude,
  // Result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [MAG_BITS-1:0]          held_peak,
  output logic [7:0]                   band_index,
  output logic                         frame_done,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic [7:0]                   brightness,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sphbc_pkg::ADDR_W-1:0] paddr,
  input  logic [sphbc_pkg::CFG_W-1:0]  pwdata,
  output logic [sphbc_pkg::CFG_W-1:0]  prdata,
  output logic                         pready
);

  import sphbc_pkg::*;

  localparam int IDX_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int CNT_W     = $clog2(BANDS + 1);
  localparam int LIM_W     = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam int FRAC_BITS = MAG_BITS - 4;
  localparam int PROD_W    = MAG_BITS + 16;
  localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

  // Configuration registers
  logic [15:0] decay_factor;
  logic [8:0]  bass_end, mid_end, bands_in_use;
  logic        cfg_wr;

  // Clearing pass
  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  // Handshake and stage control
  logic accept, mv12, mv23, mv34, mv45;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1, v2, v3, v4;

  // Band counter and decode
  logic [IDX_W-1:0] band_counter, band_counter_next;
  logic [LIM_W-1:0] limit_eff, bil_ext, idx_ext;
  logic             done0;
  band_cls_t        cls0;

  // Stage 1: read data present
  logic [IDX_W-1:0]    idx1;
  logic [MAG_BITS-1:0] mag1, byp_data1, rd_data, old1, decayed1, peak1;
  logic                done1, byp1;
  band_cls_t           cls1;
  logic [PROD_W-1:0]   prod1, shifted1;

  // Stage 2: peak known
  logic [IDX_W-1:0]    idx2;
  logic [MAG_BITS-1:0] peak2;
  logic                done2;
  band_cls_t           cls2;
  sum_t                acc_bass, acc_mid, acc_high, acc_total;
  sum_t                fin_bass2, fin_mid2, fin_high2, fin_total2, peak2_sum;

  // Stage 3: frame sums
  logic [IDX_W-1:0]    idx3;
  logic [MAG_BITS-1:0] peak3;
  logic                done3;
  sum_t                fin_bass, fin_mid, fin_high, fin_total;

  // Stage 4: products in the colour mapper
  logic [IDX_W-1:0]    idx4;
  logic [MAG_BITS-1:0] peak4;
  logic                done4;
  logic [LIM_W-1:0]    idx4_ext;

  // RAM ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [MAG_BITS-1:0] ram_wdata;

  cmap_ctl_t cmap_ctl;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor <= DECAY_RESET;
      bass_end     <= BASS_END_RESET;
      mid_end      <= MID_END_RESET;
      bands_in_use <= BANDS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DECAY:    decay_factor <= pwdata[15:0];
        REG_BASS_END: bass_end     <= pwdata[8:0];
        REG_MID_END:  mid_end      <= pwdata[8:0];
        REG_BANDS:    bands_in_use <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DECAY:    prdata = CFG_W'(decay_factor);
      REG_BASS_END: prdata = CFG_W'(bass_end);
      REG_MID_END:  prdata = CFG_W'(mid_end);
      REG_BANDS:    prdata = CFG_W'(bands_in_use);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------- clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == IDX_W'(BANDS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  // -------------------------------------------------------- stage control
  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = clearing || !rdy1;
  assign accept   = in_valid && !in_stall;
  assign mv12     = v1 && rdy2;
  assign mv23     = v2 && rdy3;
  assign mv34     = v3 && rdy4;
  assign mv45     = v4 && rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= accept ? 1'b1 : (mv12 ? 1'b0 : v1);
      v2        <= mv12   ? 1'b1 : (mv23 ? 1'b0 : v2);
      v3        <= mv23   ? 1'b1 : (mv34 ? 1'b0 : v3);
      v4        <= mv34   ? 1'b1 : (mv45 ? 1'b0 : v4);
      out_valid <= mv45   ? 1'b1 : (out_stall ? out_valid : 1'b0);
    end
  end

  // ------------------------------------------------- band counter, decode
  always_comb begin
    bil_ext = LIM_W'(bands_in_use);
    if (bands_in_use == '0) begin
      limit_eff = LIM_W'(1);
    end else if (bil_ext > LIM_W'(BANDS)) begin
      limit_eff = LIM_W'(BANDS);
    end else begin
      limit_eff = bil_ext;
    end
    idx_ext = LIM_W'(band_counter);
    done0   = (idx_ext + LIM_W'(1)) >= limit_eff;
    if (idx_ext < LIM_W'(bass_end)) begin
      cls0 = CLS_BASS;
    end else if (idx_ext < LIM_W'(mid_end)) begin
      cls0 = CLS_MID;
    end else begin
      cls0 = CLS_HIGH;
    end
    band_counter_next = done0 ? '0 : band_counter + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_counter <= '0;
    end else if (accept) begin
      band_counter <= band_counter_next;
    end
  end

  // ------------------------------------------------------- peak store RAM
  assign ram_we    = clearing || mv12;
  assign ram_waddr = clearing ? clr_addr : idx1;
  assign ram_wdata = clearing ? '0 : peak1;

  sphbc_peak_ram #(
    .DEPTH  (BANDS),
    .WIDTH  (MAG_BITS),
    .ADDR_W (IDX_W)
  ) u_peak_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (band_counter),
    .rdata (rd_data)
  );

  // ------------------------------------------------- stage 1: decay, max
  // Capture the word; bypass a write-back to the same band on this edge
  always_ff @(posedge clk) begin
    if (accept) begin
      idx1      <= band_counter;
      mag1      <= magnitude;
      done1     <= done0;
      cls1      <= cls0;
      byp1      <= mv12 && (idx1 == band_counter);
      byp_data1 <= peak1;
    end
  end

  always_comb begin
    old1     = byp1 ? byp_data1 : rd_data;
    prod1    = PROD_W'(old1) * PROD_W'(decay_factor);
    shifted1 = prod1 >> DECAY_SHIFT;
    decayed1 = (shifted1 > PROD_W'(MAG_MAX)) ? MAG_MAX : shifted1[MAG_BITS-1:0];
    peak1    = (decayed1 > mag1) ? decayed1 : mag1;
  end

  // --------------------------------------------- stage 2: accumulate sums
  always_ff @(posedge clk) begin
    if (mv12) begin
      idx2  <= idx1;
      peak2 <= peak1;
      done2 <= done1;
      cls2  <= cls1;
    end
  end

  always_comb begin
    peak2_sum  = SUM_W'(peak2);
    fin_bass2  = (cls2 == CLS_BASS) ? sat_add(acc_bass, peak2_sum) : acc_bass;
    fin_mid2   = (cls2 == CLS_MID)  ? sat_add(acc_mid, peak2_sum)  : acc_mid;
    fin_high2  = (cls2 == CLS_HIGH) ? sat_add(acc_high, peak2_sum) : acc_high;
    fin_total2 = sat_add(acc_total, peak2_sum);
  end

  // Advance the sums; restart them after the last band of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_bass  <= '0;
      acc_mid   <= '0;
      acc_high  <= '0;
      acc_total <= '0;
    end else if (mv23) begin
      acc_bass  <= done2 ? '0 : fin_bass2;
      acc_mid   <= done2 ? '0 : fin_mid2;
      acc_high  <= done2 ? '0 : fin_high2;
      acc_total <= done2 ? '0 : fin_total2;
    end
  end

  // ------------------------------------------------- stage 3: frame sums
  always_ff @(posedge clk) begin
    if (mv23) begin
      idx3      <= idx2;
      peak3     <= peak2;
      done3     <= done2;
      fin_bass  <= fin_bass2;
      fin_mid   <= fin_mid2;
      fin_high  <= fin_high2;
      fin_total <= fin_total2;
    end
  end

  // ---------------------------------------------------- stage 4: colours
  always_ff @(posedge clk) begin
    if (mv34) begin
      idx4  <= idx3;
      peak4 <= peak3;
      done4 <= done3;
    end
  end

  assign cmap_ctl = '{load_prod: mv34, load_hold: mv45 && done4};

  sphbc_colour_map #(
    .FRAC_BITS (FRAC_BITS)
  ) u_colour_map (
    .clk        (clk),
    .rst        (rst),
    .ctl        (cmap_ctl),
    .bass       (fin_bass),
    .mid        (fin_mid),
    .high       (fin_high),
    .total      (fin_total),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .brightness (brightness)
  );

  // ------------------------------------------------------ output register
  assign idx4_ext = LIM_W'(idx4);

  always_ff @(posedge clk) begin
    if (mv45) begin
      held_peak  <= peak4;
      band_index <= idx4_ext[7:0];
      frame_done <= done4;
    end
  end

endmodule

@@ sv/sphbc_peak_ram.sv @@
// ----------------------------------------------------------------------------
// sphbc_peak_ram
// Peak-hold store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sphbc_peak_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read at the write address returns the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/sphbc_colour_map.sv @@
// ----------------------------------------------------------------------------
// sphbc_colour_map
// Maps the frame's bass, mid, high and total sums to red, green, blue and
// brightness over two registered steps, and holds the last frame's colours.
// ----------------------------------------------------------------------------
module sphbc_colour_map #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sphbc_pkg::cmap_ctl_t  ctl,
  input  sphbc_pkg::sum_t       bass,
  input  sphbc_pkg::sum_t       mid,
  input  sphbc_pkg::sum_t       high,
  input  sphbc_pkg::sum_t       total,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [7:0]            brightness
);

  import sphbc_pkg::*;

  logic [COL_PROD_W-1:0] prod_bass, prod_mid, prod_high, prod_total;
  logic [7:0]            red_next, green_next, blue_next, brightness_next;

  // floor(x / 6), saturated at 255
  function automatic logic [7:0] colour_of(input logic [COL_PROD_W-1:0] x);
    logic [QM_W-1:0] m;
    m = QM_W'(x[QX_W-1:0]) * QM_W'(COL_RECIP);
    if (x >= COL_SAT_X) begin
      return COL_MAX;
    end
    return m[RECIP_SHIFT +: 8];
  endfunction

  // 100 + floor(x / 10), saturated at 255
  function automatic logic [7:0] bright_of(input logic [COL_PROD_W-1:0] x);
    logic [QM_W-1:0] m;
    m = QM_W'(x[QX_W-1:0]) * QM_W'(BRT_RECIP);
    if (x >= BRT_SAT_X) begin
      return COL_MAX;
    end
    return BRT_BASE + m[RECIP_SHIFT +: 8];
  endfunction

  // Scale the sums by the colour gains
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_bass  <= COL_PROD_W'(bass)  * COL_PROD_W'(COL_GAIN);
      prod_mid   <= COL_PROD_W'(mid)   * COL_PROD_W'(COL_GAIN);
      prod_high  <= COL_PROD_W'(high)  * COL_PROD_W'(COL_GAIN);
      prod_total <= COL_PROD_W'(total) * COL_PROD_W'(BRT_GAIN);
    end
  end

  // Drop the fraction bits, then divide by the full-scale constant
  always_comb begin
    red_next        = colour_of(prod_bass  >> FRAC_BITS);
    green_next      = colour_of(prod_mid   >> FRAC_BITS);
    blue_next       = colour_of(prod_high  >> FRAC_BITS);
    brightness_next = bright_of(prod_total >> FRAC_BITS);
  end

  // Hold the colours of the last completed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      red        <= '0;
      green      <= '0;
      blue       <= '0;
      brightness <= BRT_BASE;
    end else if (ctl.load_hold) begin
      red        <= red_next;
      green      <= green_next;
      blue       <= blue_next;
      brightness <= brightness_next;
    end
  end

endmodule
